FILE: rtl/spbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbc_pkg
// Types and constants shared by the scan point breakpoint clustering block.
// ----------------------------------------------------------------------------
package spbc_pkg;

   // field widths
   localparam int COORD_W    = 18;
   localparam int OCC_W      = 8;
   localparam int TOL_W      = 22;
   localparam int THR_W      = 7;
   localparam int MINPTS_W   = 12;
   localparam int PCOUNT_W   = 12;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int EXT_W      = 2 * DIFF_W;

   // stream word widths, padded to whole bytes
   localparam int REQ_DATA_W = ((2 * COORD_W + OCC_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_W + EXT_W + PCOUNT_W + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = TOL_W;

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE_SQ       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCCUPIED_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CLUSTER_POINTS = 2'd2;

   localparam logic [TOL_W-1:0]    TOLERANCE_SQ_RST       = 22'd94372;
   localparam logic [THR_W-1:0]    OCCUPIED_THRESHOLD_RST = 7'd50;
   localparam logic [MINPTS_W-1:0] MIN_CLUSTER_POINTS_RST = 12'd3;

   localparam int MAX_POINTS_DEF = 2048;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIST_X,
      ST_DIST_Y,
      ST_DIST_SUM,
      ST_DECIDE,
      ST_CLOSE,
      ST_DIV,
      ST_EXT_X,
      ST_EXT_Y,
      ST_EXT_SUM,
      ST_EMIT,
      ST_CLEAR,
      ST_ADD
   } state_type;

endpackage

FILE: rtl/scan_point_breakpoint_clustering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_point_breakpoint_clustering
// Groups laser hit points into clusters by the gap between neighbors and
// reports centroid, squared extent and size of each closed cluster.
// ----------------------------------------------------------------------------
// The block takes one point word at a time and is not ready again until that
// point is fully handled. A point that neither closes nor flushes a cluster
// passes through the evaluate state and, if kept, the add state, preceded by
// the distance and decide states when a cluster is open. Each emitted
// cluster also passes through the bit-serial divider that forms the centroid
// x and then y, and through the extent states; a single squarer serves the
// join distance and the extent. A scan_end point may close and emit two
// clusters. The result sits in an output register, so a stalled consumer
// holds the block only when a second result is ready. Configuration words
// are accepted at any time and must only be written while the block is idle.
module scan_point_breakpoint_clustering #(
   parameter int MAX_POINTS = spbc_pkg::MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // point_x, point_y, cell_occupancy (lowest bit up)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [spbc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   // centroid_x, centroid_y, extent_sq, point_count (lowest bit up)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [spbc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spbc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COORD_W = spbc_pkg::COORD_W;
   localparam int DIFF_W  = spbc_pkg::DIFF_W;
   localparam int SQ_W    = spbc_pkg::EXT_W;
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int SUM_W   = COORD_W + $clog2(MAX_POINTS);
   localparam int CMP_W   = (CNT_W > spbc_pkg::MINPTS_W) ? CNT_W : spbc_pkg::MINPTS_W;
   localparam int DCNT_W  = $clog2(SUM_W);
   localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_POINTS);
   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

   spbc_pkg::state_type state_ff, state_in;

   // configuration
   logic [spbc_pkg::TOL_W-1:0]    tol_ff;
   logic [spbc_pkg::THR_W-1:0]    thr_ff;
   logic [spbc_pkg::MINPTS_W-1:0] min_pts_ff;

   // latched point
   logic signed [COORD_W-1:0]     x_ff, y_ff;
   logic signed [spbc_pkg::OCC_W-1:0] occ_ff;
   logic                          end_ff;

   // running cluster
   logic signed [COORD_W-1:0]     prev_x_ff, prev_y_ff;
   logic signed [SUM_W-1:0]       sum_x_ff, sum_y_ff;
   logic signed [COORD_W-1:0]     min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          flush_ff;

   // shared squarer and accumulator
   logic signed [COORD_W-1:0]     sq_a, sq_b;
   logic signed [DIFF_W-1:0]      sq_diff;
   logic [DIFF_W-1:0]             sq_mag;
   logic [SQ_W-1:0]               sq_ff;
   logic [SQ_W-1:0]               acc_ff;
   logic [SQ_W:0]                 acc_sum;

   // bit-serial divider
   logic [SUM_W-1:0]              div_q_ff;
   logic [CNT_W-1:0]              div_rem_ff;
   logic [DCNT_W-1:0]             div_cnt_ff;
   logic                          div_sel_ff;
   logic                          div_neg_ff;
   logic [CNT_W:0]                div_trial;
   logic                          div_ge;
   logic [CNT_W:0]                div_rem_full;
   logic [SUM_W-1:0]              div_q_step;
   logic [SUM_W-1:0]              div_q_signed;
   logic                          div_last;
   logic [SUM_W-1:0]              sum_x_abs, sum_y_abs;
   logic signed [COORD_W-1:0]     cx_ff;

   // result register
   logic                          rsp_valid_ff;
   logic signed [COORD_W-1:0]     rsp_cx_ff, rsp_cy_ff;
   logic [SQ_W-1:0]               rsp_ext_ff;
   logic [spbc_pkg::PCOUNT_W-1:0] rsp_cnt_ff;
   logic                          rsp_last_ff;

   // decisions
   logic                          kept;
   logic                          join_ok;
   logic                          qualify;
   logic                          can_load;
   logic [CMP_W-1:0]              cnt_ext, need_ext;
   logic                          last_flag;

   // control
   logic accept_en, add_en, clear_en, div_init, set_break, set_flush, out_load;

   // ------------------------------------------------------------------------
   // decisions
   // ------------------------------------------------------------------------
   assign kept     = !($signed(occ_ff) > $signed({1'b0, thr_ff}));
   assign join_ok  = (acc_ff < {{(SQ_W-spbc_pkg::TOL_W){1'b0}}, tol_ff}) && (cnt_ff < CNT_MAX);
   assign cnt_ext  = CMP_W'(cnt_ff);
   assign need_ext = CMP_W'(min_pts_ff);
   assign qualify  = (cnt_ff != '0) && (cnt_ext >= need_ext);
   assign can_load = !rsp_valid_ff || rsp_tready;
   // a break at scan end leaves a one-point cluster that emits only when the
   // minimum size is at most one; otherwise the break result ends the scan
   assign last_flag = flush_ff || (end_ff && (min_pts_ff > spbc_pkg::MINPTS_W'(1)));

   // ------------------------------------------------------------------------
   // squarer operands
   // ------------------------------------------------------------------------
   always_comb begin
      sq_a = x_ff;
      sq_b = prev_x_ff;
      case (state_ff)
         spbc_pkg::ST_DIST_Y: begin
            sq_a = y_ff;
            sq_b = prev_y_ff;
         end
         spbc_pkg::ST_EXT_X: begin
            sq_a = max_x_ff;
            sq_b = min_x_ff;
         end
         spbc_pkg::ST_EXT_Y: begin
            sq_a = max_y_ff;
            sq_b = min_y_ff;
         end
         default: begin
            sq_a = x_ff;
            sq_b = prev_x_ff;
         end
      endcase
   end

   assign sq_diff = {sq_a[COORD_W-1], sq_a} - {sq_b[COORD_W-1], sq_b};
   assign sq_mag  = sq_diff[DIFF_W-1] ? DIFF_W'(-sq_diff) : DIFF_W'(sq_diff);
   assign acc_sum = {1'b0, acc_ff} + {1'b0, sq_ff};

   // ------------------------------------------------------------------------
   // divider step
   // ------------------------------------------------------------------------
   assign sum_x_abs    = sum_x_ff[SUM_W-1] ? SUM_W'(-sum_x_ff) : SUM_W'(sum_x_ff);
   assign sum_y_abs    = sum_y_ff[SUM_W-1] ? SUM_W'(-sum_y_ff) : SUM_W'(sum_y_ff);
   assign div_trial    = {div_rem_ff, div_q_ff[SUM_W-1]};
   assign div_ge       = div_trial >= {1'b0, cnt_ff};
   assign div_rem_full = div_ge ? (div_trial - {1'b0, cnt_ff}) : div_trial;
   assign div_q_step   = {div_q_ff[SUM_W-2:0], div_ge};
   assign div_q_signed = div_neg_ff ? (~div_q_step + SUM_W'(1)) : div_q_step;
   assign div_last     = (div_cnt_ff == DIV_LAST);

   // ------------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spbc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = spbc_pkg::ST_EVAL;
         end
         spbc_pkg::ST_EVAL: begin
            if (kept) begin
               state_in = (cnt_ff == '0) ? spbc_pkg::ST_ADD : spbc_pkg::ST_DIST_X;
            end else if (end_ff) begin
               state_in = spbc_pkg::ST_CLOSE;
            end else begin
               state_in = spbc_pkg::ST_IDLE;
            end
         end
         spbc_pkg::ST_DIST_X:   state_in = spbc_pkg::ST_DIST_Y;
         spbc_pkg::ST_DIST_Y:   state_in = spbc_pkg::ST_DIST_SUM;
         spbc_pkg::ST_DIST_SUM: state_in = spbc_pkg::ST_DECIDE;
         spbc_pkg::ST_DECIDE: begin
            state_in = join_ok ? spbc_pkg::ST_ADD : spbc_pkg::ST_CLOSE;
         end
         spbc_pkg::ST_CLOSE: begin
            state_in = qualify ? spbc_pkg::ST_DIV : spbc_pkg::ST_CLEAR;
         end
         spbc_pkg::ST_DIV: begin
            if (div_last && div_sel_ff) state_in = spbc_pkg::ST_EXT_X;
         end
         spbc_pkg::ST_EXT_X:   state_in = spbc_pkg::ST_EXT_Y;
         spbc_pkg::ST_EXT_Y:   state_in = spbc_pkg::ST_EXT_SUM;
         spbc_pkg::ST_EXT_SUM: state_in = spbc_pkg::ST_EMIT;
         spbc_pkg::ST_EMIT: begin
            if (can_load) state_in = spbc_pkg::ST_CLEAR;
         end
         spbc_pkg::ST_CLEAR: begin
            state_in = flush_ff ? spbc_pkg::ST_IDLE : spbc_pkg::ST_ADD;
         end
         spbc_pkg::ST_ADD: begin
            state_in = end_ff ? spbc_pkg::ST_CLOSE : spbc_pkg::ST_IDLE;
         end
         default: state_in = spbc_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer: outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      add_en     = 1'b0;
      clear_en   = 1'b0;
      div_init   = 1'b0;
      set_break  = 1'b0;
      set_flush  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         spbc_pkg::ST_IDLE:   req_tready = 1'b1;
         spbc_pkg::ST_EVAL:   set_flush  = !kept;
         spbc_pkg::ST_DECIDE: set_break  = !join_ok;
         spbc_pkg::ST_CLOSE:  div_init   = qualify;
         spbc_pkg::ST_EMIT:   out_load   = can_load;
         spbc_pkg::ST_CLEAR:  clear_en   = 1'b1;
         spbc_pkg::ST_ADD: begin
            add_en    = 1'b1;
            set_flush = end_ff;
         end
         default: req_tready = 1'b0;
      endcase
   end

   assign accept_en = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spbc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= spbc_pkg::TOLERANCE_SQ_RST;
         thr_ff     <= spbc_pkg::OCCUPIED_THRESHOLD_RST;
         min_pts_ff <= spbc_pkg::MIN_CLUSTER_POINTS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            spbc_pkg::CSR_TOLERANCE_SQ:       tol_ff <= csr_data;
            spbc_pkg::CSR_OCCUPIED_THRESHOLD: thr_ff <= csr_data[spbc_pkg::THR_W-1:0];
            spbc_pkg::CSR_MIN_CLUSTER_POINTS: min_pts_ff <= csr_data[spbc_pkg::MINPTS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // point latch, squarer and accumulator
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept_en) begin
         x_ff   <= req_tdata[COORD_W-1:0];
         y_ff   <= req_tdata[2*COORD_W-1:COORD_W];
         occ_ff <= req_tdata[2*COORD_W+spbc_pkg::OCC_W-1:2*COORD_W];
         end_ff <= req_tlast;
      end
      sq_ff <= SQ_W'(sq_mag * sq_mag);
      if (state_ff == spbc_pkg::ST_DIST_Y || state_ff == spbc_pkg::ST_EXT_Y) begin
         acc_ff <= sq_ff;
      end else if (state_ff == spbc_pkg::ST_DIST_SUM || state_ff == spbc_pkg::ST_EXT_SUM) begin
         acc_ff <= acc_sum[SQ_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // running cluster
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         min_x_ff  <= spbc_pkg::COORD_MAX;
         min_y_ff  <= spbc_pkg::COORD_MAX;
         max_x_ff  <= spbc_pkg::COORD_MIN;
         max_y_ff  <= spbc_pkg::COORD_MIN;
         cnt_ff    <= '0;
         flush_ff  <= 1'b0;
      end else begin
         if (set_flush) flush_ff <= 1'b1;
         if (set_break) flush_ff <= 1'b0;
         if (clear_en) begin
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            min_x_ff <= spbc_pkg::COORD_MAX;
            min_y_ff <= spbc_pkg::COORD_MAX;
            max_x_ff <= spbc_pkg::COORD_MIN;
            max_y_ff <= spbc_pkg::COORD_MIN;
            cnt_ff   <= '0;
            // scan end also forgets the previous point
            if (flush_ff) begin
               prev_x_ff <= '0;
               prev_y_ff <= '0;
            end
         end else if (add_en) begin
            sum_x_ff  <= sum_x_ff + {{(SUM_W-COORD_W){x_ff[COORD_W-1]}}, x_ff};
            sum_y_ff  <= sum_y_ff + {{(SUM_W-COORD_W){y_ff[COORD_W-1]}}, y_ff};
            if (x_ff < min_x_ff) min_x_ff <= x_ff;
            if (x_ff > max_x_ff) max_x_ff <= x_ff;
            if (y_ff < min_y_ff) min_y_ff <= y_ff;
            if (y_ff > max_y_ff) max_y_ff <= y_ff;
            cnt_ff    <= cnt_ff + CNT_W'(1);
            prev_x_ff <= x_ff;
            prev_y_ff <= y_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // centroid divider: x first, then y, one quotient bit a cycle
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (div_init) begin
         div_q_ff   <= sum_x_abs;
         div_neg_ff <= sum_x_ff[SUM_W-1];
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
         div_sel_ff <= 1'b0;
      end else if (state_ff == spbc_pkg::ST_DIV) begin
         if (div_last) begin
            div_rem_ff <= '0;
            div_cnt_ff <= '0;
            if (!div_sel_ff) begin
               cx_ff      <= div_q_signed[COORD_W-1:0];
               div_q_ff   <= sum_y_abs;
               div_neg_ff <= sum_y_ff[SUM_W-1];
               div_sel_ff <= 1'b1;
            end else begin
               div_q_ff <= div_q_signed;
            end
         end else begin
            div_q_ff   <= div_q_step;
            div_rem_ff <= div_rem_full[CNT_W-1:0];
            div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_cx_ff   <= cx_ff;
         rsp_cy_ff   <= div_q_ff[COORD_W-1:0];
         rsp_ext_ff  <= acc_ff;
         rsp_cnt_ff  <= cnt_ext[spbc_pkg::PCOUNT_W-1:0];
         rsp_last_ff <= last_flag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(spbc_pkg::RSP_DATA_W-2*COORD_W-SQ_W-spbc_pkg::PCOUNT_W){1'b0}},
                        rsp_cnt_ff, rsp_ext_ff, rsp_cy_ff, rsp_cx_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("cluster point count above MAX_POINTS");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   a_empty_is_clear: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (sum_x_ff == '0 && sum_y_ff == '0 &&
                          min_x_ff == spbc_pkg::COORD_MAX &&
                          max_y_ff == spbc_pkg::COORD_MIN))
      else $error("empty cluster holds stale accumulators");

   a_load_has_points: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (cnt_ff != '0 && $past(state_ff) != spbc_pkg::ST_IDLE))
      else $error("result loaded without a cluster");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scan point breakpoint clustering block. A driver
// feeds point words from a pending list and a monitor predicts the cluster
// results of every accepted point and compares them with what comes out.
// Both stream sides idle and stall in random bursts. Configuration changes
// happen between phases, once every predicted cluster has arrived.
// ----------------------------------------------------------------------------
module testbench;
   import spbc_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 200;
   localparam int STALL_LIMIT   = 3000;
   localparam int QUIET_ITEMS   = 100;
   localparam int PHASE_ITEMS   = 90;

   typedef enum logic [1:0] {WK_POINT, WK_DRAIN, WK_CSR} work_kind_t;
   typedef enum logic [1:0] {DRV_RUN, DRV_DRAIN, DRV_CSR, DRV_DONE} drv_state_t;

   typedef struct {
      work_kind_t                  kind;
      logic signed [COORD_W-1:0]   x;
      logic signed [COORD_W-1:0]   y;
      logic signed [OCC_W-1:0]     occ;
      logic                        scan_end;
      logic [CSR_IDX_W-1:0]        idx;
      logic [CSR_DATA_W-1:0]       data;
   } work_item_t;

   typedef struct {
      logic signed [COORD_W-1:0]   cx;
      logic signed [COORD_W-1:0]   cy;
      logic [EXT_W-1:0]            ext;
      logic [PCOUNT_W-1:0]         count;
      logic                        last;
   } cluster_rpt_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   work_item_t   work_q[$];
   cluster_rpt_t cluster_q[$];

   drv_state_t drv_state = DRV_RUN;
   int         gap_left = 0;
   int         settle_count = 0;
   int         drv_idle_mode = 1;
   int         rsp_idle_mode = 1;
   int         rsp_stall_left = 0;
   int         watchdog_count = 0;
   int         fail_count = 0;
   logic       stim_done = 1'b0;
   logic       results_drained = 1'b1;
   logic       tail_quiet = 1'b0;

   // stimulus planning state
   int         plan_radius = 307;
   int         plan_thr = 50;

   // predictor state and configuration copy
   logic [TOL_W-1:0]    tol_cfg = TOLERANCE_SQ_RST;
   logic [THR_W-1:0]    thr_cfg = OCCUPIED_THRESHOLD_RST;
   logic [MINPTS_W-1:0] minpts_cfg = MIN_CLUSTER_POINTS_RST;
   longint trk_prev_x, trk_prev_y, trk_sum_x, trk_sum_y;
   longint trk_min_x, trk_max_x, trk_min_y, trk_max_y;
   int     trk_count;

   scan_point_breakpoint_clustering u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- planning

   function automatic int rand_coord();
      return int'($urandom_range(0, 262143)) - 131072;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic int pick_gap(input int mode);
      if (mode == 0) return 0;
      if (mode == 1) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 17) : 0;
   endfunction

   task automatic push_point(input int x, input int y, input int occ, input logic fin);
      work_item_t w;
      w.kind     = WK_POINT;
      w.x        = x;
      w.y        = y;
      w.occ      = occ;
      w.scan_end = fin;
      w.idx      = '0;
      w.data     = '0;
      work_q.push_back(w);
   endtask

   task automatic push_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      work_item_t w;
      w.kind     = WK_CSR;
      w.x        = '0;
      w.y        = '0;
      w.occ      = '0;
      w.scan_end = 1'b0;
      w.idx      = idx;
      w.data     = value;
      work_q.push_back(w);
   endtask

   // drain, then write all three registers
   task automatic write_config(input int tol, input int thr, input int mpts);
      work_item_t w;
      w.kind     = WK_DRAIN;
      w.x        = '0;
      w.y        = '0;
      w.occ      = '0;
      w.scan_end = 1'b0;
      w.idx      = '0;
      w.data     = '0;
      work_q.push_back(w);
      push_csr(CSR_TOLERANCE_SQ, tol);
      push_csr(CSR_OCCUPIED_THRESHOLD, thr);
      push_csr(CSR_MIN_CLUSTER_POINTS, mpts);
      plan_thr    = thr;
      plan_radius = 0;
      while ((plan_radius + 1) * (plan_radius + 1) <= tol) plan_radius++;
   endtask

   task automatic plan_random_config();
      int tol;
      int thr;
      int mpts;
      case ($urandom_range(0, 9))
         0: tol = 0;
         1: tol = 4194303;
         2: tol = $urandom_range(0, 4194303);
         default: begin
            tol = $urandom_range(8, 2047);
            tol = tol * tol;
         end
      endcase
      case ($urandom_range(0, 9))
         0: thr = 0;
         1: thr = 100;
         2: thr = 127;
         default: thr = $urandom_range(0, 100);
      endcase
      case ($urandom_range(0, 15))
         0: mpts = 0;
         1: mpts = 2048;
         2: mpts = 4095;
         3, 4: mpts = 1;
         default: mpts = $urandom_range(2, 5);
      endcase
      write_config(tol, thr, mpts);
   endtask

   // one scan: a random walk with steps inside the join radius, some jumps,
   // some dropped points and some fully random noise words
   task automatic plan_scan(input int len);
      int i;
      int roll;
      int step;
      int dx;
      int dy;
      int cx;
      int cy;
      int occ;
      cx   = rand_coord();
      cy   = rand_coord();
      step = plan_radius / 2;
      for (i = 0; i < len; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            push_point(rand_coord(), rand_coord(), $urandom_range(0, 255),
                       (i == len - 1) || ($urandom_range(0, 3) == 0));
         end else begin
            if (roll < 14) begin
               cx = rand_coord();
               cy = rand_coord();
            end else begin
               dx = $urandom_range(0, 2 * step);
               dy = $urandom_range(0, 2 * step);
               cx = clamp_coord(cx + dx - step);
               cy = clamp_coord(cy + dy - step);
            end
            if ($urandom_range(0, 6) == 0) occ = $urandom_range(0, 255);
            else occ = int'($urandom_range(0, plan_thr + 1)) - 1;
            push_point(cx, cy, occ, i == len - 1);
         end
      end
   endtask

   task automatic plan_random_phase();
      int planned;
      int len;
      planned = 0;
      plan_random_config();
      while (planned < PHASE_ITEMS) begin
         if ($urandom_range(0, 7) == 0) len = $urandom_range(30, 60);
         else len = $urandom_range(1, 20);
         plan_scan(len);
         planned += len;
      end
   endtask

   // one cluster fills to the point limit, then the rest is flushed
   task automatic plan_full_cluster();
      int i;
      int cx;
      int cy;
      cx = clamp_coord(rand_coord());
      cy = clamp_coord(rand_coord());
      if (cx > 131000) cx = 131000;
      write_config(4194303, 100, 2);
      for (i = 0; i < MAX_POINTS_DEF + 2; i++)
         push_point(cx + (i % 5), cy + (i % 3), $urandom_range(0, 100),
                    i == MAX_POINTS_DEF + 1);
   endtask

   task automatic plan_directed();
      // reset settings: join radius about 307, threshold 50, three points
      push_point(0, 0, 0, 1'b0);
      push_point(100, 100, -1, 1'b0);
      push_point(200, 150, 50, 1'b0);           // at threshold: kept
      push_point(250, 200, 51, 1'b0);           // above threshold: dropped
      push_point(250, 200, 127, 1'b0);
      push_point(300, 250, -128, 1'b0);         // negative occupancy: kept
      push_point(9000, 9000, 0, 1'b0);          // breakpoint closes four points
      push_point(9100, 9000, 100, 1'b0);
      push_point(9050, 9050, 0, 1'b1);          // small flush: nothing emitted
      push_point(131071, 131071, 0, 1'b0);
      push_point(131071, 131070, 0, 1'b0);
      push_point(131000, 131071, 0, 1'b0);
      push_point(131071, 131071, 101, 1'b1);    // dropped point still flushes
      write_config(TOLERANCE_SQ_RST, OCCUPIED_THRESHOLD_RST, 1);
      push_point(-131072, -131072, 0, 1'b0);
      push_point(-131072, -131000, 0, 1'b0);
      push_point(131071, 131071, 0, 1'b1);      // close and flush in one word
      push_point(0, 0, 0, 1'b1);
      push_point(-131072, 131071, -1, 1'b0);
      push_point(131071, -131072, -1, 1'b1);
      write_config(0, 0, 0);
      push_point(5, 5, 0, 1'b0);                // zero tolerance: never joins
      push_point(5, 5, 1, 1'b0);
      push_point(5, 5, 0, 1'b1);
   endtask

   // ---------------------------------------------------------------- predictor

   task automatic clear_cluster();
      trk_sum_x = 0;
      trk_sum_y = 0;
      trk_min_x = longint'(COORD_MAX);
      trk_min_y = longint'(COORD_MAX);
      trk_max_x = longint'(COORD_MIN);
      trk_max_y = longint'(COORD_MIN);
      trk_count = 0;
   endtask

   task automatic absorb_point(input longint x, input longint y);
      trk_sum_x += x;
      trk_sum_y += y;
      if (x < trk_min_x) trk_min_x = x;
      if (x > trk_max_x) trk_max_x = x;
      if (y < trk_min_y) trk_min_y = y;
      if (y > trk_max_y) trk_max_y = y;
      trk_count++;
      trk_prev_x = x;
      trk_prev_y = y;
   endtask

   task automatic close_cluster(inout int made);
      cluster_rpt_t r;
      longint ex;
      longint ey;
      if (trk_count > 0 && trk_count >= int'(minpts_cfg)) begin
         ex      = trk_max_x - trk_min_x;
         ey      = trk_max_y - trk_min_y;
         r.cx    = trk_sum_x / longint'(trk_count);
         r.cy    = trk_sum_y / longint'(trk_count);
         r.ext   = ex * ex + ey * ey;
         r.count = trk_count;
         r.last  = 1'b0;
         cluster_q.push_back(r);
         made++;
      end
      clear_cluster();
   endtask

   task automatic cluster_step(input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py,
                               input logic signed [OCC_W-1:0] occ,
                               input logic fin);
      longint x;
      longint y;
      longint dx;
      longint dy;
      int     made;
      x    = px;
      y    = py;
      made = 0;
      if (int'(occ) <= int'(thr_cfg)) begin
         if (trk_count == 0) begin
            absorb_point(x, y);
         end else begin
            dx = x - trk_prev_x;
            dy = y - trk_prev_y;
            if (dx * dx + dy * dy < longint'(tol_cfg) && trk_count < MAX_POINTS_DEF) begin
               absorb_point(x, y);
            end else begin
               close_cluster(made);
               absorb_point(x, y);
            end
         end
      end
      if (fin) begin
         close_cluster(made);
         if (made > 0) cluster_q[cluster_q.size() - 1].last = 1'b1;
         trk_prev_x = 0;
         trk_prev_y = 0;
         clear_cluster();
      end
   endtask

   task automatic check_field(input string label, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid   <= 1'b0;
         csr_valid    <= 1'b0;
         drv_state    <= DRV_RUN;
         gap_left     <= 0;
         settle_count <= 0;
         stim_done    <= 1'b0;
      end else begin
         tail_quiet <= (work_q.size() < QUIET_ITEMS);
         case (drv_state)
            DRV_RUN: begin
               if (!req_tvalid || req_tready) begin
                  if (gap_left > 0) begin
                     req_tvalid <= 1'b0;
                     gap_left   <= gap_left - 1;
                  end else if (work_q.size() == 0) begin
                     req_tvalid <= 1'b0;
                     stim_done  <= 1'b1;
                     drv_state  <= DRV_DONE;
                  end else if (work_q[0].kind == WK_POINT) begin
                     req_tvalid <= 1'b1;
                     req_tdata  <= {{(REQ_DATA_W - 2 * COORD_W - OCC_W){1'b0}},
                                    work_q[0].occ, work_q[0].y, work_q[0].x};
                     req_tlast  <= work_q[0].scan_end;
                     void'(work_q.pop_front());
                     gap_left   <= tail_quiet ? 0 : pick_gap(drv_idle_mode);
                     if ($urandom_range(0, 63) == 0) drv_idle_mode <= $urandom_range(0, 2);
                  end else if (work_q[0].kind == WK_DRAIN) begin
                     req_tvalid   <= 1'b0;
                     settle_count <= 0;
                     drv_state    <= DRV_DRAIN;
                  end else begin
                     req_tvalid <= 1'b0;
                     csr_valid  <= 1'b1;
                     csr_index  <= work_q[0].idx;
                     csr_data   <= work_q[0].data;
                     void'(work_q.pop_front());
                     drv_state  <= DRV_CSR;
                  end
               end
            end
            DRV_DRAIN: begin
               // hold off until all clusters are out and the block sits idle
               if (results_drained && req_tready) begin
                  if (settle_count == SETTLE_CYCLES - 1) begin
                     void'(work_q.pop_front());
                     drv_state <= DRV_RUN;
                  end else begin
                     settle_count <= settle_count + 1;
                  end
               end else begin
                  settle_count <= 0;
               end
            end
            DRV_CSR: begin
               if (csr_ready) begin
                  csr_valid <= 1'b0;
                  drv_state <= DRV_RUN;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         tol_cfg    = TOLERANCE_SQ_RST;
         thr_cfg    = OCCUPIED_THRESHOLD_RST;
         minpts_cfg = MIN_CLUSTER_POINTS_RST;
         trk_prev_x = 0;
         trk_prev_y = 0;
         clear_cluster();
         rsp_tready      <= 1'b0;
         rsp_stall_left  <= 0;
         results_drained <= 1'b1;
         watchdog_count  <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOLERANCE_SQ:       tol_cfg    = csr_data[TOL_W-1:0];
               CSR_OCCUPIED_THRESHOLD: thr_cfg    = csr_data[THR_W-1:0];
               CSR_MIN_CLUSTER_POINTS: minpts_cfg = csr_data[MINPTS_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            cluster_step(req_tdata[COORD_W-1:0], req_tdata[2*COORD_W-1:COORD_W],
                         req_tdata[2*COORD_W+OCC_W-1:2*COORD_W], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (cluster_q.size() == 0) begin
               $display("%0t: unexpected cluster, expected none, got (%0d, %0d) ext %0d n %0d",
                        $time, $signed(rsp_tdata[COORD_W-1:0]),
                        $signed(rsp_tdata[2*COORD_W-1:COORD_W]),
                        rsp_tdata[2*COORD_W+EXT_W-1:2*COORD_W],
                        rsp_tdata[2*COORD_W+EXT_W+PCOUNT_W-1:2*COORD_W+EXT_W]);
               fail_count++;
            end else begin
               check_field("centroid_x", longint'(cluster_q[0].cx),
                           longint'($signed(rsp_tdata[COORD_W-1:0])));
               check_field("centroid_y", longint'(cluster_q[0].cy),
                           longint'($signed(rsp_tdata[2*COORD_W-1:COORD_W])));
               check_field("extent_sq", longint'(cluster_q[0].ext),
                           longint'(rsp_tdata[2*COORD_W+EXT_W-1:2*COORD_W]));
               check_field("point_count", longint'(cluster_q[0].count),
                           longint'(rsp_tdata[2*COORD_W+EXT_W+PCOUNT_W-1:2*COORD_W+EXT_W]));
               check_field("last_of_scan", longint'(cluster_q[0].last), longint'(rsp_tlast));
               void'(cluster_q.pop_front());
            end
         end
         results_drained <= (cluster_q.size() == 0);

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            watchdog_count <= 0;
         else
            watchdog_count <= watchdog_count + 1;

         if (tail_quiet) begin
            rsp_tready <= 1'b1;
         end else if (rsp_stall_left > 0) begin
            rsp_tready     <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
         end else if (pick_gap(rsp_idle_mode) > 0) begin
            rsp_tready     <= 1'b0;
            rsp_stall_left <= $urandom_range(0, 16);
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 127) == 0) rsp_idle_mode <= $urandom_range(0, 2);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int p;
      plan_directed();
      for (p = 0; p < 6; p++) plan_random_phase();
      plan_full_cluster();
      for (p = 0; p < 3; p++) plan_random_phase();
      write_config(TOLERANCE_SQ_RST, OCCUPIED_THRESHOLD_RST, MIN_CLUSTER_POINTS_RST);
      plan_thr = OCCUPIED_THRESHOLD_RST;
      while (work_q.size() < 40000 && p < 4) begin
         plan_scan($urandom_range(5, 25));
         if ((work_q.size() % 50) < 5) p++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(stim_done && results_drained) && watchdog_count < STALL_LIMIT)
         @(posedge clock);
      if (watchdog_count >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d clusters outstanding",
                  $time, watchdog_count, cluster_q.size());
         fail_count++;
      end else begin
         repeat (TAIL_CYCLES) @(posedge clock);
      end
      if (cluster_q.size() != 0) begin
         $display("%0t: %0d expected clusters never arrived", $time, cluster_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
